@@ rtl/core/led_ring_spinner_tail_core_defines.svh @@
// Assertion macros used by the spinner datapath
`ifndef LED_RING_SPINNER_TAIL_CORE_DEFINES_SVH
`define LED_RING_SPINNER_TAIL_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define LRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define LRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lrs_pkg.sv @@
// Types, constants and tables for the LED ring spinner
`default_nettype none
package lrs_pkg;

  localparam int RING_MAX = 8;
  localparam int RING_CAP = (RING_MAX < 8) ? RING_MAX : 8;
  localparam logic [3:0] RING_CAP_N = 4'(RING_CAP);
  localparam logic [2:0] LIT_MAX = 3'd6;

  typedef enum logic [1:0] {
    REG_STEP_INTERVAL = 2'd0,
    REG_TAIL_LENGTH   = 2'd1,
    REG_RING_COUNT    = 2'd2,
    REG_RING_MAP      = 2'd3
  } lrs_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BLACK,
    ST_MUL,
    ST_LIT
  } lrs_state_t;

  typedef struct packed {
    logic tick;        // count one tick, latch its color
    logic advance;     // clear count, move head, start frame
    logic emit_black;  // load a black word
    logic mul;         // form channel products for current tail slot
    logic emit_lit;    // load a scaled color word
  } lrs_cmd_t;

  typedef struct packed {
    logic fire;        // count reached the interval
    logic out_free;    // output register can take a word
    logic black_last;  // current black word is the last one
    logic lit_zero;    // no lit pixels in this frame
    logic lit_last;    // current lit word is the last one
  } lrs_status_t;

  function automatic logic [23:0] color_rgb(input logic [3:0] ci);
    logic [23:0] c;
    unique case (ci)
      4'd0:    c = {8'd0,   8'd100, 8'd250};
      4'd1:    c = {8'd168, 8'd161, 8'd154};
      4'd2:    c = {8'd255, 8'd166, 8'd99};
      4'd3:    c = {8'd255, 8'd141, 8'd184};
      4'd4:    c = {8'd137, 8'd125, 8'd255};
      4'd5:    c = {8'd121, 8'd181, 8'd103};
      4'd6:    c = {8'd52,  8'd235, 8'd67};
      4'd7:    c = {8'd255, 8'd163, 8'd117};
      4'd8:    c = {8'd108, 8'd116, 8'd230};
      4'd9:    c = {8'd209, 8'd164, 8'd131};
      4'd10:   c = {8'd171, 8'd179, 8'd93};
      4'd11:   c = {8'd104, 8'd147, 8'd221};
      default: c = 24'd0;  // black, and indices past the table
    endcase
    return c;  // {blue, green, red}
  endfunction

  function automatic logic [7:0] tail_level(input logic [2:0] t);
    logic [7:0] l;
    unique case (t)
      3'd0:    l = 8'd255;
      3'd1:    l = 8'd140;
      3'd2:    l = 8'd60;
      3'd3:    l = 8'd25;
      3'd4:    l = 8'd10;
      3'd5:    l = 8'd4;
      default: l = 8'd0;
    endcase
    return l;
  endfunction

  // h mod n for h <= 8, 1 <= n <= 8: at most eight subtract steps
  function automatic logic [2:0] ring_mod(input logic [3:0] h, input logic [3:0] n);
    logic [3:0] r;
    r = h;
    for (int i = 0; i < 8; i++) begin
      if (r >= n) r = r - n;
    end
    return r[2:0];
  endfunction

  // floor(p / 255) for p <= 255*255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [15:0] s;
    s = p + {8'd0, p[15:8]} + 16'd1;
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lrs_ctrl.sv @@
// Frame sequencer for the ring spinner
`default_nettype none
module lrs_ctrl
  import lrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  lrs_status_t stat,
  output lrs_cmd_t    cmd
);

  lrs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no word is taken while reset is held
        if (!rst) begin
          s_tready = 1'b1;
          if (s_tvalid) begin
            cmd.tick   = 1'b1;
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat.fire) begin
          cmd.advance = 1'b1;
          state_next  = ST_BLACK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BLACK: begin
        if (stat.out_free) begin
          cmd.emit_black = 1'b1;
          if (stat.black_last) begin
            state_next = stat.lit_zero ? ST_IDLE : ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_LIT;
      end
      ST_LIT: begin
        if (stat.out_free) begin
          cmd.emit_lit = 1'b1;
          state_next   = stat.lit_last ? ST_IDLE : ST_MUL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/lrs_datapath.sv @@
// Registers, counters, color scaling and output word for the ring spinner
`default_nettype none
`include "led_ring_spinner_tail_core_defines.svh"
module lrs_datapath
  import lrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [3:0]  color,
  input  lrs_cmd_t    cmd,
  output lrs_status_t stat,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  logic [15:0] step_interval;
  logic [3:0]  tail_length;
  logic [3:0]  ring_count;
  logic [63:0] ring_map;

  logic [15:0] elapsed;
  logic [2:0]  head;
  logic [23:0] rgb;
  logic [2:0]  idx;
  logic [2:0]  slot;
  logic [2:0]  pos;
  logic [15:0] prod_r, prod_g, prod_b;

  logic [3:0]  n;
  logic [2:0]  lit;
  logic [3:0]  n_m1;
  logic [7:0]  black_px, lit_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= 16'd68;
      tail_length   <= 4'd3;
      ring_count    <= 4'd6;
      ring_map      <= 64'h0706050403020100;
    end else if (cfg_we) begin
      unique case (lrs_reg_t'(cfg_index))
        REG_STEP_INTERVAL: step_interval <= cfg_data[15:0];
        REG_TAIL_LENGTH:   tail_length   <= cfg_data[3:0];
        REG_RING_COUNT:    ring_count    <= cfg_data[3:0];
        REG_RING_MAP:      ring_map      <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (ring_count > RING_CAP_N) n = RING_CAP_N;
    else if (ring_count == 4'd0) n = 4'd1;
    else n = ring_count;
  end
  assign n_m1     = n - 4'd1;
  assign lit      = (tail_length > {1'b0, LIT_MAX}) ? LIT_MAX : tail_length[2:0];
  assign black_px = ring_map[{idx, 3'b000} +: 8];
  assign lit_px   = ring_map[{pos, 3'b000} +: 8];

  assign stat.fire       = (elapsed >= step_interval);
  assign stat.out_free   = !m_tvalid || m_tready;
  assign stat.black_last = ({1'b0, idx} == n_m1);
  assign stat.lit_zero   = (lit == 3'd0);
  assign stat.lit_last   = (slot == lit - 3'd1);

  // tick counting and head
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= 16'd0;
      head    <= 3'd0;
    end else if (cmd.tick) begin
      if (elapsed != 16'hFFFF) elapsed <= elapsed + 16'd1;
    end else if (cmd.advance) begin
      elapsed <= 16'd0;
      head    <= ring_mod({1'b0, head} + 4'd1, n);
    end
  end

  // frame walk
  always_ff @(posedge clk) begin
    if (cmd.tick) rgb <= color_rgb(color);
    if (cmd.advance) begin
      idx  <= 3'd0;
      slot <= 3'd0;
    end
    if (cmd.emit_black) begin
      idx <= idx + 3'd1;
      pos <= head;
    end
    if (cmd.mul) begin
      prod_r <= rgb[7:0]   * tail_level(slot);
      prod_g <= rgb[15:8]  * tail_level(slot);
      prod_b <= rgb[23:16] * tail_level(slot);
    end
    if (cmd.emit_lit) begin
      slot <= slot + 3'd1;
      pos  <= (pos == 3'd0) ? n_m1[2:0] : pos - 3'd1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_black || cmd.emit_lit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_black) begin
      m_tdata <= {24'd0, black_px};
      m_tlast <= stat.black_last && stat.lit_zero;
    end else if (cmd.emit_lit) begin
      m_tdata <= {div255(prod_b), div255(prod_g), div255(prod_r), lit_px};
      m_tlast <= stat.lit_last;
    end
  end

  `LRS_ASSERT_NOW(a_emit_slot, (cmd.emit_black || cmd.emit_lit), stat.out_free, "word loaded over a waiting word")
  `LRS_ASSERT_NEXT(a_head_range, cmd.advance, ({1'b0, head} < n), "head outside ring after advance")
  `LRS_ASSERT_NEXT(a_count_clear, cmd.advance, (elapsed == 16'd0), "tick count not cleared on advance")

endmodule
`default_nettype wire

@@ rtl/core/led_ring_spinner_tail_core.sv @@
// Top level of the LED ring spinner: sequencer plus datapath
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata[3:0] color
//  m_*       out  m_tvalid/m_tready    m_tdata pixel,r,g,b; m_tlast frame end
//  cfg_*     in   cfg_we               cfg_index, cfg_data
//
// When no step is due, a tick is counted in ST_IDLE and compared in ST_CHECK.
// A step then emits n black words, one a cycle while the output is free, and
// each lit word as a product state then a load state (shared multiplier slot).
// Output stalls hold the sequencer; the last word may wait in the output
// register while the next tick is taken.
// rst is synchronous; it restores the register defaults, count and head.
`default_nettype none
module led_ring_spinner_tail_core
  import lrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] color, [7:4] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] pixel_index, [15:8] red, [23:16] green, [31:24] blue
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  lrs_cmd_t    cmd;
  lrs_status_t stat;

  lrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .color     (s_tdata[3:0]),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire
